>>> hdl/sgtr_pkg.sv
// Shared types, codes and the 5x7 font table for the scaled glyph text rasterizer.
`default_nettype none

package sgtr_pkg;

	localparam int CoordW = 11;
	localparam int Cells = 35;
	localparam int GlyphRows = 7;
	localparam int GlyphCount = 59;

	localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] CFG_FG_COLOR = 3'd2;
	localparam logic [2:0] CFG_BG_COLOR = 3'd3;
	localparam logic [2:0] CFG_SCALE    = 3'd4;

	localparam logic OP_BEGIN = 1'b0;
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;

	typedef struct packed {
		logic [8:0] col_start;
		logic [8:0] col_end;
		logic [8:0] row_start;
		logic [8:0] row_end;
		logic       visible;
	} geom_t;

	// Column 0 sits in the top byte of each entry, bit 0 of a column is the top row.
	localparam logic [39:0] GLYPH_ROM [GlyphCount] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543
	};

	// Folds lower case to upper case and maps any code outside space to Z to a question mark.
	function automatic logic [5:0] fold_code(input logic [7:0] code);
		logic [7:0] c;
		c = code;
		if (c >= 8'd97 && c <= 8'd122) begin
			c = c - 8'd32;
		end
		if (c < 8'd32 || c > 8'd90) begin
			c = 8'd63;
		end
		c = c - 8'd32;
		return c[5:0];
	endfunction

	// Cell bits in column-major order: bit col*7+row.
	function automatic logic [Cells-1:0] glyph_bits(input logic [5:0] idx);
		logic [39:0] entry;
		logic [Cells-1:0] bits;
		entry = GLYPH_ROM[idx];
		bits = '0;
		for (int c = 0; c < 5; c++) begin
			bits[c*GlyphRows +: GlyphRows] = entry[(4-c)*8 +: GlyphRows];
		end
		return bits;
	endfunction

endpackage

`default_nettype wire

>>> hdl/sgtr_cell_unit.sv
// Clipping and window coordinate unit for one glyph cell.
`default_nettype none

module sgtr_cell_unit #(
	parameter int PANEL_WIDTH = 172,
	parameter int PANEL_HEIGHT = 320,
	parameter int COLUMN_OFFSET = 35
) (
	input  wire logic [sgtr_pkg::CoordW-1:0] x0,
	input  wire logic [sgtr_pkg::CoordW-1:0] y0,
	input  wire logic [3:0]                  scale,
	output sgtr_pkg::geom_t                  geom
);

	localparam int W = sgtr_pkg::CoordW;
	localparam logic [W-1:0] PW_C = W'(PANEL_WIDTH);
	localparam logic [W-1:0] PH_C = W'(PANEL_HEIGHT);
	localparam logic [W-1:0] CO_C = W'(COLUMN_OFFSET);

	logic [W-1:0] x1, y1, xe, ye, cs, ce, re;
	logic vis;

	always_comb begin
		x1 = x0 + {{(W-4){1'b0}}, scale};
		y1 = y0 + {{(W-4){1'b0}}, scale};
		xe = (x1 > PW_C) ? PW_C : x1;
		ye = (y1 > PH_C) ? PH_C : y1;
		vis = (scale != 4'd0) && (x0 < PW_C) && (y0 < PH_C);
		cs = x0 + CO_C;
		ce = xe - W'(1) + CO_C;
		re = ye - W'(1);
		geom.col_start = vis ? cs[8:0] : 9'd0;
		geom.col_end   = vis ? ce[8:0] : 9'd0;
		geom.row_start = vis ? y0[8:0] : 9'd0;
		geom.row_end   = vis ? re[8:0] : 9'd0;
		geom.visible   = vis;
	end

endmodule

`default_nettype wire

>>> hdl/scaled_glyph_text_rasterizer.sv
// Top level of the scaled glyph text rasterizer: cursor, cell sequencer and output register.
//
// Channel   Dir  Payload
// s_axis    in   tuser = op, tdata = char_code
// m_axis    out  tdata = cell window and color, tuser = visible, tlast = last cell
// cfg       in   cfg_index selects the register, cfg_data carries its value
//
// A drawn character first fetches its glyph, then sends its 35 cells one per cycle while m_axis
// does not stall, through the shared cell unit, with the cursor advanced on the last cell.
// Begin-string, newline and ignored requests are taken in the idle state and give no result.
// A stall on m_axis holds the sequencer; the next request is accepted while the last cell waits.
// Reset is asynchronous and active low; the register file and cursor start at their defaults.
`default_nettype none

module scaled_glyph_text_rasterizer #(
	parameter int PANEL_WIDTH = 172,
	parameter int PANEL_HEIGHT = 320,
	parameter int COLUMN_OFFSET = 35
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_code
	input  wire logic        s_axis_tuser,  // [0] op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [8:0] column_start, [17:9] column_end, [26:18] row_start, [35:27] row_end,
	// [51:36] pixel_color, [55:52] zero
	output logic [55:0]      m_axis_tdata,
	output logic             m_axis_tuser,  // [0] visible
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int W = sgtr_pkg::CoordW;
	localparam logic [W-1:0] PW_C = W'(PANEL_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_CELL = 2'b10
	} state_t;

	state_t state_q;
	logic [7:0]  origin_x_q;
	logic [8:0]  origin_y_q;
	logic [15:0] fg_color_q, bg_color_q;
	logic [3:0]  scale_q;
	logic [8:0]  cursor_x_q;
	logic [9:0]  cursor_y_q;
	logic        stopped_q;
	logic [sgtr_pkg::Cells-1:0] glyph_q;
	logic [5:0]  cell_q;
	logic [2:0]  row_q;
	logic [W-1:0] x0_q, y0_q;
	logic [6:0]  adv_q;

	logic [8:0]  col_start_q, col_end_q, row_start_q, row_end_q;
	logic [15:0] color_q;
	logic        visible_q, last_q, out_valid_q;

	sgtr_pkg::geom_t geom;
	logic in_fire, cell_load, cell_last;
	logic [6:0]  adv_c;
	logic [10:0] ny;
	logic [9:0]  nx;
	logic [8:0]  nx_sat;
	logic [W-1:0] stop_sum;

	sgtr_cell_unit #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_HEIGHT(PANEL_HEIGHT),
		.COLUMN_OFFSET(COLUMN_OFFSET)
	) u_cell (
		.x0(x0_q),
		.y0(y0_q),
		.scale(scale_q),
		.geom(geom)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign cell_load = (state_q == ST_CELL) && (!out_valid_q || m_axis_tready);
	assign cell_last = (cell_q == 6'(sgtr_pkg::Cells - 1));

	always_comb begin
		adv_c = {1'b0, scale_q, 2'b00} + {2'b00, scale_q, 1'b0};
		ny = {1'b0, cursor_y_q} + {4'b0000, scale_q, 3'b000};
		nx = {1'b0, cursor_x_q} + {3'b000, adv_q};
		nx_sat = nx[9] ? 9'h1FF : nx[8:0];
		stop_sum = {2'b00, nx_sat} + {4'b0000, adv_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= 8'd0;
			origin_y_q <= 9'd0;
			fg_color_q <= 16'hFFFF;
			bg_color_q <= 16'h0000;
			scale_q <= 4'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sgtr_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data[7:0];
				sgtr_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data[8:0];
				sgtr_pkg::CFG_FG_COLOR: fg_color_q <= cfg_data;
				sgtr_pkg::CFG_BG_COLOR: bg_color_q <= cfg_data;
				sgtr_pkg::CFG_SCALE:    scale_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cursor_x_q <= 9'd0;
			cursor_y_q <= 10'd0;
			stopped_q <= 1'b0;
			cell_q <= 6'd0;
			row_q <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser == sgtr_pkg::OP_BEGIN) begin
							cursor_x_q <= {1'b0, origin_x_q};
							cursor_y_q <= {1'b0, origin_y_q};
							stopped_q <= 1'b0;
						end else if (!stopped_q) begin
							if (s_axis_tdata == sgtr_pkg::CHAR_NEWLINE) begin
								cursor_y_q <= ny[10] ? 10'h3FF : ny[9:0];
								cursor_x_q <= {1'b0, origin_x_q};
							end else begin
								cell_q <= 6'd0;
								row_q <= 3'd0;
								state_q <= ST_CELL;
							end
						end
					end
				end
				ST_CELL: begin
					if (cell_load) begin
						cell_q <= cell_q + 6'd1;
						row_q <= (row_q == 3'(sgtr_pkg::GlyphRows - 1)) ? 3'd0 : row_q + 3'd1;
						if (cell_last) begin
							state_q <= ST_IDLE;
							cursor_x_q <= nx_sat;
							if (stop_sum > PW_C) begin
								stopped_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			glyph_q <= sgtr_pkg::glyph_bits(sgtr_pkg::fold_code(s_axis_tdata));
			x0_q <= {2'b00, cursor_x_q};
			y0_q <= {1'b0, cursor_y_q};
			adv_q <= adv_c;
		end else if (cell_load) begin
			glyph_q <= {1'b0, glyph_q[sgtr_pkg::Cells-1:1]};
			if (row_q == 3'(sgtr_pkg::GlyphRows - 1)) begin
				y0_q <= {1'b0, cursor_y_q};
				x0_q <= x0_q + {{(W-4){1'b0}}, scale_q};
			end else begin
				y0_q <= y0_q + {{(W-4){1'b0}}, scale_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cell_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_load) begin
			col_start_q <= geom.col_start;
			col_end_q <= geom.col_end;
			row_start_q <= geom.row_start;
			row_end_q <= geom.row_end;
			visible_q <= geom.visible;
			color_q <= glyph_q[0] ? fg_color_q : bg_color_q;
			last_q <= cell_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0000, color_q, row_end_q, row_start_q, col_end_q, col_start_q};
	assign m_axis_tuser = visible_q;
	assign m_axis_tlast = last_q;

	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |-> (cell_q <= 6'(sgtr_pkg::Cells - 1)))
		else $error("cell counter beyond the last cell");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_load && cell_last) |=> (state_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
		else $error("last cell did not end the character");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CELL) |-> !s_axis_tready)
		else $error("input accepted during a character");

	a_invisible_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[35:0] == 36'd0))
		else $error("invisible cell carries coordinates");

endmodule

`default_nettype wire

>>> dv/tb_scaled_glyph_text_rasterizer.sv
// Self-checking testbench for the scaled glyph text rasterizer: predicts every cell of every glyph.
module tb_scaled_glyph_text_rasterizer;

	localparam int PANEL_W = 172;
	localparam int PANEL_H = 320;
	localparam int WINDOW_X_SHIFT = 35;
	localparam logic OP_DRAW = 1'b1;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT = 200000;
	localparam int HOLD_CYCLES = 600;
	localparam int PHASE_ITEMS = 105;

	// Column 0 of a glyph sits in the top byte, bit 0 of a column is the top row.
	localparam logic [39:0] FONT5X7 [59] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
		40'h6314081463, 40'h0708700807, 40'h6151494543
	};

	typedef struct packed {
		logic       op;
		logic [7:0] code;
	} text_req_t;

	typedef struct packed {
		logic [8:0]  col_start;
		logic [8:0]  col_end;
		logic [8:0]  row_start;
		logic [8:0]  row_end;
		logic [15:0] color;
		logic        visible;
		logic        last;
	} cell_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	text_req_t text_queue[$];
	cell_t     cells_due[$];

	int org_x = 0;
	int org_y = 0;
	logic [15:0] fg_color = 16'hFFFF;
	logic [15:0] bg_color = 16'h0000;
	int cell_scale = 1;
	int cursor_x = 0;
	int cursor_y = 0;
	bit line_stopped = 1'b0;

	int live_items = 0;
	int error_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	bit hold_arm = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	scaled_glyph_text_rasterizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report_mismatch(input string what);
		if (error_count < 30) begin
			$display("ERROR at %0t: %s", $realtime, what);
		end
		error_count++;
	endtask

	// Updates the cursor for one accepted request and queues the cells it must produce.
	function automatic void rasterize_request(input logic op, input logic [7:0] code);
		int adv, ny, nx, ch, x0, y0, x1, y1, k, v;
		logic [39:0] glyph;
		logic [7:0] column;
		cell_t c;
		adv = 6 * cell_scale;
		if (op == sgtr_pkg::OP_BEGIN) begin
			cursor_x = org_x;
			cursor_y = org_y;
			line_stopped = 1'b0;
			live_items++;
			return;
		end
		if (line_stopped) begin
			return;
		end
		live_items++;
		if (code == sgtr_pkg::CHAR_NEWLINE) begin
			ny = cursor_y + 8 * cell_scale;
			cursor_y = (ny > 1023) ? 1023 : ny;
			cursor_x = org_x;
			return;
		end
		ch = code;
		if (ch >= 97 && ch <= 122) begin
			ch = ch - 32;
		end
		if (ch < 32 || ch > 90) begin
			ch = 63;
		end
		glyph = FONT5X7[ch - 32];
		k = 0;
		for (int col = 0; col < 5; col++) begin
			column = glyph[(4 - col) * 8 +: 8];
			for (int row = 0; row < 7; row++) begin
				x0 = cursor_x + col * cell_scale;
				y0 = cursor_y + row * cell_scale;
				x1 = (x0 + cell_scale > PANEL_W) ? PANEL_W : x0 + cell_scale;
				y1 = (y0 + cell_scale > PANEL_H) ? PANEL_H : y0 + cell_scale;
				c = '0;
				c.visible = cell_scale != 0 && x0 < PANEL_W && y0 < PANEL_H;
				if (c.visible) begin
					v = x0 + WINDOW_X_SHIFT;
					c.col_start = v[8:0];
					v = x1 - 1 + WINDOW_X_SHIFT;
					c.col_end = v[8:0];
					c.row_start = y0[8:0];
					v = y1 - 1;
					c.row_end = v[8:0];
				end
				c.color = column[row] ? fg_color : bg_color;
				c.last = (k == sgtr_pkg::Cells - 1);
				cells_due.push_back(c);
				k++;
			end
		end
		nx = cursor_x + adv;
		cursor_x = (nx > 511) ? 511 : nx;
		if (cursor_x > PANEL_W - adv) begin
			line_stopped = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				rasterize_request(s_axis_tuser, s_axis_tdata);
			end
			if (text_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= text_queue[0].op;
				s_axis_tdata <= text_queue[0].code;
				void'(text_queue.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		cell_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (cells_due.size() == 0) begin
					report_mismatch($sformatf("unexpected cell tdata=%h", m_axis_tdata));
				end else begin
					want = cells_due.pop_front();
					if (m_axis_tdata[8:0] !== want.col_start)
						report_mismatch($sformatf("column_start %0d, want %0d",
							m_axis_tdata[8:0], want.col_start));
					if (m_axis_tdata[17:9] !== want.col_end)
						report_mismatch($sformatf("column_end %0d, want %0d",
							m_axis_tdata[17:9], want.col_end));
					if (m_axis_tdata[26:18] !== want.row_start)
						report_mismatch($sformatf("row_start %0d, want %0d",
							m_axis_tdata[26:18], want.row_start));
					if (m_axis_tdata[35:27] !== want.row_end)
						report_mismatch($sformatf("row_end %0d, want %0d",
							m_axis_tdata[35:27], want.row_end));
					if (m_axis_tdata[51:36] !== want.color)
						report_mismatch($sformatf("pixel_color %h, want %h",
							m_axis_tdata[51:36], want.color));
					if (m_axis_tdata[55:52] !== 4'd0)
						report_mismatch($sformatf("pad bits %h", m_axis_tdata[55:52]));
					if (m_axis_tuser !== want.visible)
						report_mismatch($sformatf("visible %b, want %b",
							m_axis_tuser, want.visible));
					if (m_axis_tlast !== want.last)
						report_mismatch($sformatf("last %b, want %b",
							m_axis_tlast, want.last));
				end
			end
			m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic push_req(input logic op, input logic [7:0] code);
		text_req_t r;
		r.op = op;
		r.code = code;
		text_queue.push_back(r);
	endtask

	task automatic drain();
		int n;
		n = 0;
		while ((text_queue.size() != 0 || s_axis_tvalid || cells_due.size() != 0)
				&& n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		if (n >= DRAIN_LIMIT) begin
			report_mismatch($sformatf("block stalled with %0d cells outstanding",
				cells_due.size()));
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sgtr_pkg::CFG_ORIGIN_X: org_x = val[7:0];
			sgtr_pkg::CFG_ORIGIN_Y: org_y = val[8:0];
			sgtr_pkg::CFG_FG_COLOR: fg_color = val;
			sgtr_pkg::CFG_BG_COLOR: bg_color = val;
			sgtr_pkg::CFG_SCALE:    cell_scale = val[3:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// One string: a begin followed by characters, now and then cut short by an early begin.
	task automatic queue_random_line();
		int len, r, span;
		span = (cell_scale == 0) ? 30 : PANEL_W / (6 * cell_scale) + 3;
		len = $urandom_range(1, span);
		push_req(sgtr_pkg::OP_BEGIN, 8'($urandom));
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				push_req(OP_DRAW, sgtr_pkg::CHAR_NEWLINE);
			end else if (r < 18) begin
				push_req(OP_DRAW, 8'($urandom_range(97, 122)));
			end else if (r < 26) begin
				push_req(OP_DRAW, 8'($urandom));
			end else if (r < 29) begin
				push_req(sgtr_pkg::OP_BEGIN, 8'($urandom));
			end else begin
				push_req(OP_DRAW, 8'($urandom_range(32, 90)));
			end
		end
	endtask

	initial begin
		int idle_plan [4];
		int stall_plan [4];
		int r, target;
		idle_plan = '{0, 56, 0, 15};
		stall_plan = '{0, 0, 56, 15};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_req(sgtr_pkg::OP_BEGIN, 8'hFF);
		push_req(OP_DRAW, 8'd32);
		push_req(OP_DRAW, 8'd90);
		push_req(OP_DRAW, 8'd97);
		push_req(OP_DRAW, 8'd122);
		push_req(OP_DRAW, 8'd0);
		push_req(OP_DRAW, 8'd255);
		push_req(OP_DRAW, 8'd48);
		push_req(OP_DRAW, sgtr_pkg::CHAR_NEWLINE);
		push_req(OP_DRAW, 8'd96);
		drain();

		// Bottom-right origin at the largest scale: clipped cells, an immediate stop,
		// and a cursor row that must saturate instead of wrapping back onto the panel.
		write_reg(sgtr_pkg::CFG_ORIGIN_X, 16'd171);
		write_reg(sgtr_pkg::CFG_ORIGIN_Y, 16'd319);
		write_reg(sgtr_pkg::CFG_FG_COLOR, 16'h0000);
		write_reg(sgtr_pkg::CFG_BG_COLOR, 16'hFFFF);
		write_reg(sgtr_pkg::CFG_SCALE, 16'd15);
		push_req(sgtr_pkg::OP_BEGIN, 8'h00);
		push_req(OP_DRAW, 8'd65);
		push_req(OP_DRAW, 8'd66);
		push_req(OP_DRAW, sgtr_pkg::CHAR_NEWLINE);
		push_req(sgtr_pkg::OP_BEGIN, 8'h5A);
		repeat (6) push_req(OP_DRAW, sgtr_pkg::CHAR_NEWLINE);
		push_req(OP_DRAW, 8'd77);
		drain();

		// A zero scale leaves every cell invisible and never moves the cursor.
		write_reg(sgtr_pkg::CFG_ORIGIN_X, 16'd0);
		write_reg(sgtr_pkg::CFG_ORIGIN_Y, 16'd0);
		write_reg(sgtr_pkg::CFG_SCALE, 16'd0);
		push_req(sgtr_pkg::OP_BEGIN, 8'h00);
		push_req(OP_DRAW, 8'd72);
		push_req(OP_DRAW, sgtr_pkg::CHAR_NEWLINE);
		push_req(OP_DRAW, 8'd73);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = idle_plan[p];
			stall_pct = stall_plan[p];
			write_reg(sgtr_pkg::CFG_ORIGIN_X, 16'($urandom_range(0, 171)));
			write_reg(sgtr_pkg::CFG_ORIGIN_Y, 16'($urandom_range(0, 319)));
			write_reg(sgtr_pkg::CFG_FG_COLOR, 16'($urandom));
			write_reg(sgtr_pkg::CFG_BG_COLOR, 16'($urandom));
			r = $urandom_range(99);
			if (r < 60) begin
				write_reg(sgtr_pkg::CFG_SCALE, 16'($urandom_range(1, 2)));
			end else if (r < 85) begin
				write_reg(sgtr_pkg::CFG_SCALE, 16'($urandom_range(3, 6)));
			end else begin
				write_reg(sgtr_pkg::CFG_SCALE, 16'($urandom_range(7, 15)));
			end
			target = live_items + PHASE_ITEMS;
			while (live_items < target) begin
				queue_random_line();
				if (p == 0) begin
					hold_arm = 1'b1;
				end
				while (text_queue.size() != 0) @(negedge clk);
			end
			drain();
		end

		if (cells_due.size() != 0) begin
			report_mismatch($sformatf("%0d cells never arrived", cells_due.size()));
		end
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
hdl/sgtr_pkg.sv
hdl/sgtr_cell_unit.sv
hdl/scaled_glyph_text_rasterizer.sv
dv/tb_scaled_glyph_text_rasterizer.sv
